>>> hdl/fcsa_pkg.sv
package fcsa_pkg;

  // Number of slots in the bitmap; the count and slot fields are sized for it.
  localparam int NUM_SLOTS  = 16;

  // Field widths of the stream items.
  localparam int COUNT_W    = 5;
  localparam int SLOT_W     = 4;
  localparam int TICKET_W   = 16;
  localparam int KIND_W     = 2;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 32;
  // Width used for slot arithmetic and bound checks.
  localparam int LIM_W      = 8;

  // Operation selector carried on s_tuser.
  localparam logic FUNC_RESERVE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result kinds carried on m_tuser.
  localparam logic [KIND_W-1:0] KIND_GRANTED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd3;

  // Source of a result loaded into the output register.
  localparam logic [2:0] SRC_REJECT   = 3'd0;
  localparam logic [2:0] SRC_RELEASED = 3'd1;
  localparam logic [2:0] SRC_QUEUED   = 3'd2;
  localparam logic [2:0] SRC_GRANT    = 3'd3;
  localparam logic [2:0] SRC_PEND     = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;       // capture the accepted item
    logic       search;      // register the first-fit result
    logic       clear_run;   // free the released run
    logic       load_head;   // read the queue head size into the search size
    logic       enqueue;     // push the request size, consume a ticket
    logic       grant_now;   // grant the current reserve at once
    logic       grant_head;  // grant the queue head and pop it
    logic       pend_rel;    // hold a released result
    logic       emit;        // load the output register
    logic [2:0] emit_src;
    logic       emit_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_func;
    logic req_bad;
    logic q_empty;
    logic q_full;
    logic q_one;
    logic fit_ok;
    logic out_free;
  } status_t;

endpackage

>>> hdl/fcsa_datapath.sv
module fcsa_datapath
  import fcsa_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [S_TDATA_W-1:0] in_data,
  input  logic                 in_func,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [M_TDATA_W-1:0] out_data,
  output logic [KIND_W-1:0]    out_kind,
  output logic                 out_last
);

  localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PAD_W  = M_TDATA_W - TICKET_W - SLOT_W - COUNT_W;
  localparam logic [LIM_W-1:0]  LIM_SLOTS = LIM_W'(NUM_SLOTS);
  localparam logic [QIDX_W-1:0] QLAST     = QIDX_W'(QUEUE_DEPTH - 1);

  // Mask of a run of cnt slots starting at first.
  function automatic logic [NUM_SLOTS-1:0] run_mask(input logic [COUNT_W-1:0] cnt,
                                                    input logic [LIM_W-1:0]   first);
    logic [NUM_SLOTS-1:0] ones;
    ones = '1;
    return (~(ones << cnt)) << first;
  endfunction

  logic                 req_func;
  logic [COUNT_W-1:0]   req_count;
  logic [SLOT_W-1:0]    req_start;
  logic [NUM_SLOTS-1:0] busy;
  logic [TICKET_W-1:0]  next_ticket;
  logic [TICKET_W-1:0]  serving_ticket;
  logic [COUNT_W-1:0]   waiting_sizes [QUEUE_DEPTH];
  logic [QIDX_W-1:0]    head;
  logic [QIDX_W-1:0]    tail;
  logic [FILL_W-1:0]    fill;
  logic [COUNT_W-1:0]   want;
  logic                 fit_ok;
  logic [SIDX_W-1:0]    fit_slot;
  logic [KIND_W-1:0]    pend_kind;
  logic [TICKET_W-1:0]  pend_ticket;
  logic [SIDX_W-1:0]    pend_slot;
  logic [COUNT_W-1:0]   pend_count;
  logic [TICKET_W-1:0]  out_ticket;
  logic [SLOT_W-1:0]    out_slot;
  logic [COUNT_W-1:0]   out_count;

  logic                 hit;
  logic [SIDX_W-1:0]    hit_slot;
  logic [QIDX_W-1:0]    head_inc;
  logic [QIDX_W-1:0]    tail_inc;
  logic [QIDX_W-1:0]    rd_addr;
  logic [NUM_SLOTS-1:0] fit_mask;
  logic                 req_bad;

  assign head_inc = (head == QLAST) ? '0 : head + 1'b1;
  assign tail_inc = (tail == QLAST) ? '0 : tail + 1'b1;
  assign rd_addr  = cmd.grant_head ? head_inc : head;
  assign fit_mask = run_mask(want, LIM_W'(fit_slot));

  // Range checks of the held request.
  always_comb begin
    if (req_func == FUNC_RESERVE) begin
      req_bad = (req_count == '0) || (LIM_W'(req_count) > LIM_SLOTS);
    end else begin
      req_bad = (LIM_W'(req_start) + LIM_W'(req_count)) > LIM_SLOTS;
    end
  end

  // First fit: every start slot is checked in parallel, the lowest one wins.
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if ((want != '0) && (LIM_W'(s) + LIM_W'(want) <= LIM_SLOTS) &&
          ((busy & run_mask(want, LIM_W'(s))) == '0)) begin
        hit      = 1'b1;
        hit_slot = SIDX_W'(s);
      end
    end
  end

  // Request capture and search size.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_func  <= in_func;
      req_count <= in_data[COUNT_W-1:0];
      req_start <= in_data[COUNT_W +: SLOT_W];
      want      <= in_data[COUNT_W-1:0];
    end else if (cmd.load_head) begin
      want <= waiting_sizes[rd_addr];
    end
    if (cmd.search) begin
      fit_ok   <= hit;
      fit_slot <= hit_slot;
    end
  end

  // Waiting request sizes.
  always_ff @(posedge clk) begin
    if (cmd.enqueue) begin
      waiting_sizes[tail] <= req_count;
    end
  end

  // Slot bitmap, tickets and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= '0;
      next_ticket    <= '0;
      serving_ticket <= '0;
      head           <= '0;
      tail           <= '0;
      fill           <= '0;
    end else begin
      if (cmd.clear_run) begin
        busy <= busy & ~run_mask(req_count, LIM_W'(req_start));
      end else if (cmd.grant_now || cmd.grant_head) begin
        busy <= busy | fit_mask;
      end
      if (cmd.enqueue || cmd.grant_now) begin
        next_ticket <= next_ticket + 1'b1;
      end
      if (cmd.grant_now || cmd.grant_head) begin
        serving_ticket <= serving_ticket + 1'b1;
      end
      if (cmd.enqueue) begin
        tail <= tail_inc;
        fill <= fill + 1'b1;
      end else if (cmd.grant_head) begin
        head <= head_inc;
        fill <= fill - 1'b1;
      end
    end
  end

  // Held result, sent once the following search has decided its last flag.
  always_ff @(posedge clk) begin
    if (cmd.pend_rel) begin
      pend_kind   <= KIND_RELEASED;
      pend_ticket <= '0;
      pend_slot   <= '0;
      pend_count  <= '0;
    end else if (cmd.grant_head) begin
      pend_kind   <= KIND_GRANTED;
      pend_ticket <= serving_ticket;
      pend_slot   <= fit_slot;
      pend_count  <= want;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last <= cmd.emit_last;
      case (cmd.emit_src)
        SRC_RELEASED: begin
          out_kind   <= KIND_RELEASED;
          out_ticket <= '0;
          out_slot   <= '0;
          out_count  <= '0;
        end
        SRC_QUEUED: begin
          out_kind   <= KIND_QUEUED;
          out_ticket <= next_ticket;
          out_slot   <= '0;
          out_count  <= '0;
        end
        SRC_GRANT: begin
          out_kind   <= KIND_GRANTED;
          out_ticket <= next_ticket;
          out_slot   <= SLOT_W'(fit_slot);
          out_count  <= want;
        end
        SRC_PEND: begin
          out_kind   <= pend_kind;
          out_ticket <= pend_ticket;
          out_slot   <= SLOT_W'(pend_slot);
          out_count  <= pend_count;
        end
        default: begin
          out_kind   <= KIND_REJECTED;
          out_ticket <= '0;
          out_slot   <= '0;
          out_count  <= '0;
        end
      endcase
    end
  end

  assign out_data = {{PAD_W{1'b0}}, out_count, out_slot, out_ticket};

  assign status.req_func = req_func;
  assign status.req_bad  = req_bad;
  assign status.q_empty  = (fill == '0);
  assign status.q_full   = (fill == FILL_W'(QUEUE_DEPTH));
  assign status.q_one    = (fill == FILL_W'(1));
  assign status.fit_ok   = fit_ok;
  assign status.out_free = !out_valid || out_ready;

endmodule

>>> hdl/fcsa_ctrl.sv
module fcsa_ctrl
  import fcsa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_FINAL  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of one item.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EVAL;
        end
      end

      // Range checks, queue checks and the clearing of a released run.
      ST_EVAL: begin
        if (status.out_free) begin
          if (status.req_bad) begin
            cmd.emit      = 1'b1;
            cmd.emit_src  = SRC_REJECT;
            cmd.emit_last = 1'b1;
            state_next    = ST_IDLE;
          end else if (status.req_func == FUNC_RESERVE) begin
            if (status.q_empty) begin
              state_next = ST_SEARCH;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (status.q_full) begin
                cmd.emit_src = SRC_REJECT;
              end else begin
                cmd.emit_src = SRC_QUEUED;
                cmd.enqueue  = 1'b1;
              end
              state_next = ST_IDLE;
            end
          end else begin
            cmd.clear_run = 1'b1;
            if (status.q_empty) begin
              cmd.emit      = 1'b1;
              cmd.emit_src  = SRC_RELEASED;
              cmd.emit_last = 1'b1;
              state_next    = ST_IDLE;
            end else begin
              cmd.pend_rel  = 1'b1;
              cmd.load_head = 1'b1;
              state_next    = ST_SEARCH;
            end
          end
        end
      end

      ST_SEARCH: begin
        cmd.search = 1'b1;
        state_next = ST_DECIDE;
      end

      // Grant or queue a reserve; on a release send the held result and serve the head.
      ST_DECIDE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.req_func == FUNC_RESERVE) begin
            cmd.emit_last = 1'b1;
            if (status.fit_ok) begin
              cmd.emit_src  = SRC_GRANT;
              cmd.grant_now = 1'b1;
            end else begin
              cmd.emit_src = SRC_QUEUED;
              cmd.enqueue  = 1'b1;
            end
            state_next = ST_IDLE;
          end else begin
            cmd.emit_src  = SRC_PEND;
            cmd.emit_last = !status.fit_ok;
            if (status.fit_ok) begin
              cmd.grant_head = 1'b1;
              cmd.load_head  = 1'b1;
              state_next     = status.q_one ? ST_FINAL : ST_SEARCH;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end

      ST_FINAL: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_src  = SRC_PEND;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/fifo_contiguous_slot_allocator.sv
// Channel   Dir  tdata (low bit up)                           tuser     tlast
// s_axis    in   slot_count[4:0], start_slot[8:5], zeros      func      -
// m_axis    out  ticket[15:0], granted_slot[19:16],            kind[1:0] last
//                granted_count[24:20], zeros
//
// A rejected reserve, or one queued behind others, is answered in EVAL; one
// that runs the first-fit search goes on through SEARCH and DECIDE. A release
// is answered in EVAL when nothing waits; else each waiting head it serves
// runs SEARCH and DECIDE, ending after a head that does not fit or in FINAL.
// Reset (rst, synchronous) frees all slots and empties the queue. The block
// takes one item at a time and holds while the output register is not taken.
module fifo_contiguous_slot_allocator
  import fcsa_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // slot_count, start_slot
  input  logic                 s_tuser,   // func
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // ticket, granted_slot, granted_count
  output logic [KIND_W-1:0]    m_tuser,   // kind
  output logic                 m_tlast
);

  cmd_t    cmd;
  status_t status;

  fcsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fcsa_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_func   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

>>> tb/fifo_contiguous_slot_allocator_tb.sv
module fifo_contiguous_slot_allocator_tb;
  import fcsa_pkg::*;

  localparam int QUEUE_DEPTH = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 30;

  // Bit positions of the result fields inside m_tdata.
  localparam int TKT_LO = 0;
  localparam int GSL_LO = TICKET_W;
  localparam int GCN_LO = TICKET_W + SLOT_W;

  // One result as the block should report it.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TICKET_W-1:0] ticket;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } alloc_result_t;

  // A run that has been granted and may be handed back later.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } slot_run_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = FUNC_RESERVE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]    m_tuser;
  logic                 m_tlast;

  // Shadow copy of the allocator state.
  logic [NUM_SLOTS-1:0] busy_map = '0;
  logic [TICKET_W-1:0]  next_tkt = '0;
  logic [TICKET_W-1:0]  serve_tkt = '0;
  logic [COUNT_W-1:0]   wait_size [QUEUE_DEPTH];
  int                   q_head = 0;
  int                   q_tail = 0;
  int                   q_fill = 0;

  alloc_result_t        pending_results[$];
  slot_run_t            granted_runs[$];
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   cycle_cnt = 0;
  bit                   failed = 1'b0;

  fifo_contiguous_slot_allocator #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #5 clk = ~clk;

  // Mask of count slots starting at start.
  function automatic logic [NUM_SLOTS-1:0] run_bits(input int start, input int count);
    logic [NUM_SLOTS-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (i >= start && i < start + count) m[i] = 1'b1;
    end
    return m;
  endfunction

  // Lowest start slot of a free run of the given length.
  function automatic bit first_fit(input int count, output int start);
    start = 0;
    if (count == 0 || count > NUM_SLOTS) return 1'b0;
    for (int s = 0; s + count <= NUM_SLOTS; s++) begin
      if ((busy_map & run_bits(s, count)) == '0) begin
        start = s;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_result(input logic [KIND_W-1:0] kind,
                                      input logic [TICKET_W-1:0] ticket,
                                      input int slot, input int count);
    alloc_result_t r;
    slot_run_t     run;
    r.kind   = kind;
    r.ticket = ticket;
    r.slot   = SLOT_W'(slot);
    r.count  = COUNT_W'(count);
    r.last   = 1'b0;
    pending_results.push_back(r);
    if (kind == KIND_GRANTED) begin
      run.slot  = SLOT_W'(slot);
      run.count = COUNT_W'(count);
      granted_runs.push_back(run);
    end
  endfunction

  // Work out every result one accepted item causes and update the shadow state.
  function automatic void predict_alloc(input logic func, input logic [COUNT_W-1:0] cnt,
                                        input logic [SLOT_W-1:0] st);
    int            fs;
    int            want;
    int            n;
    alloc_result_t r;
    n = int'(cnt);
    if (func == FUNC_RESERVE) begin
      if (n == 0 || n > NUM_SLOTS) begin
        push_result(KIND_REJECTED, '0, 0, 0);
      end else if (q_fill == 0 && first_fit(n, fs)) begin
        push_result(KIND_GRANTED, next_tkt, fs, n);
        busy_map |= run_bits(fs, n);
        next_tkt++;
        serve_tkt++;
      end else if (q_fill >= QUEUE_DEPTH) begin
        push_result(KIND_REJECTED, '0, 0, 0);
      end else begin
        push_result(KIND_QUEUED, next_tkt, 0, 0);
        wait_size[q_tail] = cnt;
        q_tail = (q_tail + 1) % QUEUE_DEPTH;
        q_fill++;
        next_tkt++;
      end
    end else if (int'(st) + n > NUM_SLOTS) begin
      push_result(KIND_REJECTED, '0, 0, 0);
    end else begin
      busy_map &= ~run_bits(int'(st), n);
      push_result(KIND_RELEASED, '0, 0, 0);
      // Serve waiting heads in order until one does not fit.
      while (q_fill > 0) begin
        want = int'(wait_size[q_head]);
        if (!first_fit(want, fs)) break;
        busy_map |= run_bits(fs, want);
        push_result(KIND_GRANTED, serve_tkt, fs, want);
        serve_tkt++;
        q_head = (q_head + 1) % QUEUE_DEPTH;
        q_fill--;
      end
    end
    r = pending_results.pop_back();
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  // Offer one item, hold it until it is taken, then predict its results.
  task automatic send_item(input logic func, input logic [COUNT_W-1:0] cnt,
                           input logic [SLOT_W-1:0] st);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[COUNT_W-1:0] = cnt;
    d[COUNT_W+SLOT_W-1:COUNT_W] = st;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_alloc(func, cnt, st);
  endtask

  // Stop offering items and wait for every outstanding result.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Bad counts, bad release runs and empty releases.
  task automatic test_rejects();
    send_item(FUNC_RESERVE, 5'd0, 4'd0);
    send_item(FUNC_RESERVE, 5'd31, 4'd15);
    send_item(FUNC_RELEASE, 5'd2, 4'd15);
    send_item(FUNC_RELEASE, 5'd16, 4'd1);
    send_item(FUNC_RELEASE, 5'd16, 4'd0);
    send_item(FUNC_RELEASE, 5'd0, 4'd15);
    wait_drained();
  endtask

  // First-fit placement around a hole left by a release.
  task automatic test_first_fit();
    send_item(FUNC_RESERVE, 5'd3, 4'd0);
    send_item(FUNC_RESERVE, 5'd2, 4'd10);
    send_item(FUNC_RESERVE, 5'd4, 4'd0);
    send_item(FUNC_RELEASE, 5'd2, 4'd3);
    send_item(FUNC_RESERVE, 5'd1, 4'd0);
    send_item(FUNC_RESERVE, 5'd2, 4'd0);
    send_item(FUNC_RELEASE, 5'd16, 4'd0);
    wait_drained();
  endtask

  // Fill the queue, hit the full case, then serve all heads in one release.
  task automatic test_queue_service();
    send_item(FUNC_RESERVE, 5'd16, 4'd0);
    for (int i = 0; i < QUEUE_DEPTH; i++) send_item(FUNC_RESERVE, 5'd1, SLOT_W'(i));
    send_item(FUNC_RESERVE, 5'd5, 4'd0);
    send_item(FUNC_RELEASE, 5'd0, 4'd0);
    send_item(FUNC_RELEASE, 5'd16, 4'd0);
    send_item(FUNC_RELEASE, 5'd16, 4'd0);
    wait_drained();
  endtask

  // Mostly well-formed reserve and release traffic, with some broken items.
  task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
    int        pick;
    int        idx;
    slot_run_t run;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int i = 0; i < n_items; i++) begin
      // Hold off once so the block runs completely dry mid-phase.
      if (i == n_items / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 50) begin
        if ($urandom_range(99) < 80)
          send_item(FUNC_RESERVE, COUNT_W'($urandom_range(1, 6)), SLOT_W'($urandom));
        else
          send_item(FUNC_RESERVE, COUNT_W'($urandom_range(7, NUM_SLOTS)), SLOT_W'($urandom));
      end else if (pick < 85 && granted_runs.size() > 0) begin
        idx = $urandom_range(granted_runs.size() - 1);
        run = granted_runs[idx];
        granted_runs.delete(idx);
        send_item(FUNC_RELEASE, run.count, run.slot);
      end else if (pick < 93) begin
        send_item(FUNC_RELEASE, COUNT_W'($urandom_range(0, NUM_SLOTS)),
                  SLOT_W'($urandom_range(0, NUM_SLOTS - 1)));
      end else if ($urandom_range(1) == 0) begin
        send_item(FUNC_RESERVE, 5'd0, SLOT_W'($urandom));
      end else begin
        send_item(FUNC_RESERVE, COUNT_W'($urandom_range(NUM_SLOTS + 1, 31)),
                  SLOT_W'($urandom));
      end
    end
    wait_drained();
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: kind %0d, tdata %h", m_tuser, m_tdata);
        failed = 1'b1;
      end else begin
        want_r = pending_results.pop_front();
        check_field("kind", 32'(want_r.kind), 32'(m_tuser));
        check_field("ticket", 32'(want_r.ticket), 32'(m_tdata[TKT_LO +: TICKET_W]));
        check_field("granted_slot", 32'(want_r.slot), 32'(m_tdata[GSL_LO +: SLOT_W]));
        check_field("granted_count", 32'(want_r.count), 32'(m_tdata[GCN_LO +: COUNT_W]));
        check_field("last", 32'(want_r.last), 32'(m_tlast));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("fifo_contiguous_slot_allocator_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 88;
    test_rejects();
    test_first_fit();
    test_queue_service();
    test_random_traffic(25, 31, 88);
    test_random_traffic(25, 88, 31);
    test_random_traffic(25, 0, 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("fifo_contiguous_slot_allocator_tb passed");
    end else begin
      $display("fifo_contiguous_slot_allocator_tb failed");
    end
    $finish;
  end

endmodule
